/* src/scc_pkg.sv */
// Shared widths and constants for the segment circle crossing test.
`default_nettype none

package scc_pkg;

   localparam int COORD_W = 32;
   localparam int RAD_W   = 31;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int DOT_W   = PROD_W + 1;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int MAG_W   = PROD_W;
   localparam int HALF_W  = MAG_W / 2;
   localparam int RR_W    = 2 * RAD_W;
   localparam int RR_LO_W = RR_W / 2;
   localparam int RR_HI_W = RR_W - RR_LO_W;
   localparam int CPART_W = 2 * HALF_W;
   localparam int RPART_W = RR_HI_W + HALF_W;
   localparam int WIDE_W  = 2 * MAG_W;

   localparam int REQ_FIELDS_W = 6 * COORD_W + RAD_W;
   localparam int REQ_W        = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_W        = 8;

endpackage

`default_nettype wire

/* src/segment_circle_crossing_test.sv */
// Segment circle crossing test: top level, difference and product stages.
//
// One stream in, one stream out. A req beat carries a segment (start, end),
// a circle center and a radius, all fixed point; every req beat yields
// exactly one rsp beat whose bit 0 says whether the circle blocks the path.
// The test is exact: squared cross product against radius squared times
// squared segment length, with a dot product rejecting centers past the end
// point and a start equal to the end giving 0.
// There are seven register stages: differences, 33x33 products, sums,
// magnitude, split partial products of the wide squares, wide sums,
// compare. Throughput is one beat per cycle unless all stages are full and
// rsp_tready is low; every stage has a valid bit and a ready chain that
// fills empty stages, so beats keep entering while a result waits.
// When the receiver holds rsp_tready low the pipeline fills up and
// req_tready drops only once all seven stages hold a beat; nothing is lost
// or repeated. Synchronous reset empties the pipeline; data is not cleared.
`default_nettype none

module segment_circle_crossing_test (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // start_x, start_y, end_x, end_y, center_x, center_y, radius, zero pad
   input  wire logic [scc_pkg::REQ_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // crosses, zero pad
   output logic [scc_pkg::RSP_W-1:0]        rsp_tdata
);
   import scc_pkg::*;

   logic signed [COORD_W-1:0] sx, sy, ex, ey, cx, cy;
   logic        [RAD_W-1:0]   rad;

   logic s1_en, s2_en, s3_en, s4_en, sub_ready;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;

   logic signed [DIFF_W-1:0] s1_dx_in, s1_dy_in, s1_ax_in, s1_ay_in, s1_bx_in, s1_by_in;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic        [RAD_W-1:0]  s1_rad_ff;
   logic                     s1_degen_in, s1_degen_ff;

   logic signed [PROD_W-1:0] s2_adx_in, s2_ady_in, s2_bdy_in, s2_bdx_in, s2_dxx_in, s2_dyy_in;
   logic signed [PROD_W-1:0] s2_adx_ff, s2_ady_ff, s2_bdy_ff, s2_bdx_ff, s2_dxx_ff, s2_dyy_ff;
   logic        [RR_W-1:0]   s2_rr_in, s2_rr_ff;
   logic                     s2_degen_ff;

   logic signed [DOT_W-1:0]  s3_dot, s3_cross_in, s3_cross_ff;
   logic        [MAG_W-1:0]  s3_len_in, s3_len_ff;
   logic        [RR_W-1:0]   s3_rr_ff;
   logic                     s3_reject_in, s3_reject_ff, s3_degen_ff;

   logic signed [DOT_W-1:0]  s4_neg;
   logic        [MAG_W-1:0]  s4_mag_in, s4_mag_ff, s4_len_ff;
   logic        [RR_W-1:0]   s4_rr_ff;
   logic                     s4_gate_in, s4_gate_ff;

   assign sx  = req_tdata[COORD_W-1:0];
   assign sy  = req_tdata[2*COORD_W-1:COORD_W];
   assign ex  = req_tdata[3*COORD_W-1:2*COORD_W];
   assign ey  = req_tdata[4*COORD_W-1:3*COORD_W];
   assign cx  = req_tdata[5*COORD_W-1:4*COORD_W];
   assign cy  = req_tdata[6*COORD_W-1:5*COORD_W];
   assign rad = req_tdata[6*COORD_W+RAD_W-1:6*COORD_W];

   assign s4_en      = !s4_v_ff || sub_ready;
   assign s3_en      = !s3_v_ff || s4_en;
   assign s2_en      = !s2_v_ff || s3_en;
   assign s1_en      = !s1_v_ff || s2_en;
   assign req_tready = s1_en;

   assign s1_dx_in    = {sx[COORD_W-1], sx} - {ex[COORD_W-1], ex};
   assign s1_dy_in    = {sy[COORD_W-1], sy} - {ey[COORD_W-1], ey};
   assign s1_ax_in    = {ex[COORD_W-1], ex} - {cx[COORD_W-1], cx};
   assign s1_ay_in    = {ey[COORD_W-1], ey} - {cy[COORD_W-1], cy};
   assign s1_bx_in    = {sx[COORD_W-1], sx} - {cx[COORD_W-1], cx};
   assign s1_by_in    = {sy[COORD_W-1], sy} - {cy[COORD_W-1], cy};
   assign s1_degen_in = (sx == ex) && (sy == ey);

   assign s2_adx_in = PROD_W'(s1_ax_ff) * PROD_W'(s1_dx_ff);
   assign s2_ady_in = PROD_W'(s1_ay_ff) * PROD_W'(s1_dy_ff);
   assign s2_bdy_in = PROD_W'(s1_bx_ff) * PROD_W'(s1_dy_ff);
   assign s2_bdx_in = PROD_W'(s1_by_ff) * PROD_W'(s1_dx_ff);
   assign s2_dxx_in = PROD_W'(s1_dx_ff) * PROD_W'(s1_dx_ff);
   assign s2_dyy_in = PROD_W'(s1_dy_ff) * PROD_W'(s1_dy_ff);
   assign s2_rr_in  = RR_W'(s1_rad_ff) * RR_W'(s1_rad_ff);

   assign s3_dot       = {s2_adx_ff[PROD_W-1], s2_adx_ff} + {s2_ady_ff[PROD_W-1], s2_ady_ff};
   assign s3_reject_in = !s3_dot[DOT_W-1] && (s3_dot != '0);
   assign s3_cross_in  = {s2_bdy_ff[PROD_W-1], s2_bdy_ff} - {s2_bdx_ff[PROD_W-1], s2_bdx_ff};
   assign s3_len_in    = {{(MAG_W-SQ_W){1'b0}}, s2_dxx_ff[SQ_W-1:0]}
                       + {{(MAG_W-SQ_W){1'b0}}, s2_dyy_ff[SQ_W-1:0]};

   assign s4_neg     = -s3_cross_ff;
   assign s4_mag_in  = s3_cross_ff[DOT_W-1] ? s4_neg[MAG_W-1:0] : s3_cross_ff[MAG_W-1:0];
   assign s4_gate_in = !s3_degen_ff && !s3_reject_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s1_en) s1_v_ff <= req_tvalid;
         if (s2_en) s2_v_ff <= s1_v_ff;
         if (s3_en) s3_v_ff <= s2_v_ff;
         if (s4_en) s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_dx_ff    <= s1_dx_in;
         s1_dy_ff    <= s1_dy_in;
         s1_ax_ff    <= s1_ax_in;
         s1_ay_ff    <= s1_ay_in;
         s1_bx_ff    <= s1_bx_in;
         s1_by_ff    <= s1_by_in;
         s1_rad_ff   <= rad;
         s1_degen_ff <= s1_degen_in;
      end
      if (s2_en) begin
         s2_adx_ff   <= s2_adx_in;
         s2_ady_ff   <= s2_ady_in;
         s2_bdy_ff   <= s2_bdy_in;
         s2_bdx_ff   <= s2_bdx_in;
         s2_dxx_ff   <= s2_dxx_in;
         s2_dyy_ff   <= s2_dyy_in;
         s2_rr_ff    <= s2_rr_in;
         s2_degen_ff <= s1_degen_ff;
      end
      if (s3_en) begin
         s3_cross_ff  <= s3_cross_in;
         s3_len_ff    <= s3_len_in;
         s3_rr_ff     <= s2_rr_ff;
         s3_reject_ff <= s3_reject_in;
         s3_degen_ff  <= s2_degen_ff;
      end
      if (s4_en) begin
         s4_mag_ff  <= s4_mag_in;
         s4_len_ff  <= s3_len_ff;
         s4_rr_ff   <= s3_rr_ff;
         s4_gate_ff <= s4_gate_in;
      end
   end

   scc_wide_cmp u_wide_cmp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s4_v_ff),
      .in_ready   (sub_ready),
      .in_mag     (s4_mag_ff),
      .in_len     (s4_len_ff),
      .in_rr      (s4_rr_ff),
      .in_gate    (s4_gate_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && s1_v_ff && s4_v_ff))
      else $error("input stalled while the pipeline has room");

   a_degen_zero_length: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && s2_degen_ff) |-> (s2_dxx_ff == '0 && s2_dyy_ff == '0))
      else $error("degenerate segment with nonzero length products");

   a_len_zero_iff_degen: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff |-> ((s3_len_ff == '0) == s3_degen_ff))
      else $error("squared length disagrees with degenerate flag");
`endif

endmodule

`default_nettype wire

/* src/scc_wide_cmp.sv */
// Split wide squares and the final cross-square against radius-square compare.
`default_nettype none

module scc_wide_cmp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [scc_pkg::MAG_W-1:0]   in_mag,
   input  wire logic [scc_pkg::MAG_W-1:0]   in_len,
   input  wire logic [scc_pkg::RR_W-1:0]    in_rr,
   input  wire logic                        in_gate,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [scc_pkg::RSP_W-1:0]        rsp_tdata   // [0] crosses
);
   import scc_pkg::*;

   logic                 s5_en, s6_en, s7_en;
   logic                 s5_v_ff, s6_v_ff, s7_v_ff;
   logic                 s5_gate_ff, s6_gate_ff, s7_hit_ff;
   logic [HALF_W-1:0]    c_hi, c_lo, l_hi, l_lo;
   logic [RR_HI_W-1:0]   r_hi;
   logic [RR_LO_W-1:0]   r_lo;
   logic [CPART_W-1:0]   s5_chh_ff, s5_chl_ff, s5_cll_ff;
   logic [RPART_W-1:0]   s5_rhh_ff, s5_rhl_ff, s5_rlh_ff, s5_rll_ff;
   logic [CPART_W-1:0]   s5_chh_in, s5_chl_in, s5_cll_in;
   logic [RPART_W-1:0]   s5_rhh_in, s5_rhl_in, s5_rlh_in, s5_rll_in;
   logic [WIDE_W-1:0]    s6_lhs_in, s6_rhs_in, s6_lhs_ff, s6_rhs_ff;
   logic                 s7_hit_in;

   assign s7_en    = !s7_v_ff || rsp_tready;
   assign s6_en    = !s6_v_ff || s7_en;
   assign s5_en    = !s5_v_ff || s6_en;
   assign in_ready = s5_en;

   assign c_hi = in_mag[MAG_W-1:HALF_W];
   assign c_lo = in_mag[HALF_W-1:0];
   assign l_hi = in_len[MAG_W-1:HALF_W];
   assign l_lo = in_len[HALF_W-1:0];
   assign r_hi = in_rr[RR_W-1:RR_LO_W];
   assign r_lo = in_rr[RR_LO_W-1:0];

   assign s5_chh_in = CPART_W'(c_hi) * CPART_W'(c_hi);
   assign s5_chl_in = CPART_W'(c_hi) * CPART_W'(c_lo);
   assign s5_cll_in = CPART_W'(c_lo) * CPART_W'(c_lo);
   assign s5_rhh_in = RPART_W'(r_hi) * RPART_W'(l_hi);
   assign s5_rhl_in = RPART_W'(r_hi) * RPART_W'(l_lo);
   assign s5_rlh_in = RPART_W'(r_lo) * RPART_W'(l_hi);
   assign s5_rll_in = RPART_W'(r_lo) * RPART_W'(l_lo);

   assign s6_lhs_in = {s5_chh_ff, {(2 * HALF_W){1'b0}}}
                    + {{(WIDE_W - CPART_W - HALF_W - 1){1'b0}}, s5_chl_ff,
                       {(HALF_W + 1){1'b0}}}
                    + {{(WIDE_W - CPART_W){1'b0}}, s5_cll_ff};
   assign s6_rhs_in = {{(WIDE_W - RPART_W - HALF_W - RR_LO_W){1'b0}}, s5_rhh_ff,
                       {(HALF_W + RR_LO_W){1'b0}}}
                    + {{(WIDE_W - RPART_W - RR_LO_W){1'b0}}, s5_rhl_ff,
                       {RR_LO_W{1'b0}}}
                    + {{(WIDE_W - RPART_W - HALF_W){1'b0}}, s5_rlh_ff,
                       {HALF_W{1'b0}}}
                    + {{(WIDE_W - RPART_W){1'b0}}, s5_rll_ff};

   assign s7_hit_in = s6_gate_ff && (s6_rhs_ff >= s6_lhs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else begin
         if (s5_en) s5_v_ff <= in_valid;
         if (s6_en) s6_v_ff <= s5_v_ff;
         if (s7_en) s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_en) begin
         s5_chh_ff  <= s5_chh_in;
         s5_chl_ff  <= s5_chl_in;
         s5_cll_ff  <= s5_cll_in;
         s5_rhh_ff  <= s5_rhh_in;
         s5_rhl_ff  <= s5_rhl_in;
         s5_rlh_ff  <= s5_rlh_in;
         s5_rll_ff  <= s5_rll_in;
         s5_gate_ff <= in_gate;
      end
      if (s6_en) begin
         s6_lhs_ff  <= s6_lhs_in;
         s6_rhs_ff  <= s6_rhs_in;
         s6_gate_ff <= s5_gate_ff;
      end
      if (s7_en) begin
         s7_hit_ff <= s7_hit_in;
      end
   end

   assign rsp_tvalid = s7_v_ff;
   assign rsp_tdata  = {{(RSP_W - 1){1'b0}}, s7_hit_ff};

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking stream testbench for the segment circle crossing test.
`timescale 1ns / 1ps

module tb_top;
   import scc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 16;
   localparam int CALC_W       = 160;
   localparam int ONE          = 32'sh0001_0000;
   localparam int TEN          = 10 * ONE;
   localparam int CMIN         = 32'sh8000_0000;
   localparam int CMAX         = 32'sh7fff_ffff;
   localparam int RMAX         = 32'sh7fff_ffff;

   typedef struct packed {
      logic [REQ_W-REQ_FIELDS_W-1:0] pad;
      logic [RAD_W-1:0]              radius;
      logic signed [COORD_W-1:0]     center_y;
      logic signed [COORD_W-1:0]     center_x;
      logic signed [COORD_W-1:0]     end_y;
      logic signed [COORD_W-1:0]     end_x;
      logic signed [COORD_W-1:0]     start_y;
      logic signed [COORD_W-1:0]     start_x;
   } crossing_query_type;

   typedef enum {BY_MODEL, KNOWN_CLEAR, KNOWN_BLOCKED} verdict_src_type;

   typedef struct {
      int              sx, sy, ex, ey, cx, cy, r;
      verdict_src_type verdict;
   } directed_row_type;

   localparam int N_ROWS = 20;

   directed_row_type directed_rows [N_ROWS] = '{
      '{0, 0, 0, 0, 0, 0, ONE, KNOWN_CLEAR},
      '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, RMAX, KNOWN_CLEAR},
      '{-TEN, 0, TEN, 0, 0, 0, ONE, KNOWN_BLOCKED},
      '{-TEN, 0, TEN, 0, 2 * TEN, 0, RMAX, KNOWN_CLEAR},
      '{-TEN, 0, TEN, 0, -2 * TEN, 0, ONE, BY_MODEL},
      '{-TEN, 0, TEN, 0, 0, ONE, ONE, KNOWN_BLOCKED},
      '{-TEN, 0, TEN, 0, 0, ONE + 1, ONE, KNOWN_CLEAR},
      '{-TEN, 0, TEN, 0, TEN, ONE / 2, ONE, BY_MODEL},
      '{-TEN, 0, TEN, 0, TEN, 2 * ONE, ONE, KNOWN_CLEAR},
      '{-TEN, 0, TEN, 0, ONE, 0, 0, KNOWN_BLOCKED},
      '{-TEN, 0, TEN, 0, ONE, 1, 0, KNOWN_CLEAR},
      '{-TEN, 0, TEN, 0, TEN + 1, 0, 0, KNOWN_CLEAR},
      '{0, -TEN, 0, TEN, 0, 0, 0, KNOWN_BLOCKED},
      '{CMIN, CMIN, CMAX, CMAX, 0, 0, 0, BY_MODEL},
      '{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, RMAX, BY_MODEL},
      '{CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, RMAX, BY_MODEL},
      '{CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 0, BY_MODEL},
      '{TEN, TEN, -TEN, -TEN, -TEN, -TEN, 0, KNOWN_BLOCKED},
      '{-1, -1, 0, 0, CMAX, CMIN, RMAX, BY_MODEL},
      '{CMIN, 0, CMAX, 0, CMAX, CMAX, RMAX, BY_MODEL}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   bit expected_crossings [$];
   int failures = 0;
   int cycle_count = 0;
   int sent_beats = 0;
   int taken_beats = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   segment_circle_crossing_test u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("segment_circle_crossing_test: mismatch");
         $finish;
      end
   end

   // exact blocking verdict for one query
   function automatic bit circle_blocks_path(crossing_query_type q);
      logic signed [CALC_W-1:0] sx, sy, ex, ey, cx, cy, rad;
      logic signed [CALC_W-1:0] dx, dy, ax, ay, bx, by;
      logic signed [CALC_W-1:0] dot, crs, lhs, len2, rhs;
      sx = q.start_x;
      sy = q.start_y;
      ex = q.end_x;
      ey = q.end_y;
      cx = q.center_x;
      cy = q.center_y;
      rad = {{(CALC_W-RAD_W){1'b0}}, q.radius};
      if (sx == ex && sy == ey) return 1'b0;
      dx = sx - ex;
      dy = sy - ey;
      ax = ex - cx;
      ay = ey - cy;
      bx = sx - cx;
      by = sy - cy;
      dot = ax * dx + ay * dy;
      if (dot > 0) return 1'b0;
      crs = bx * dy - by * dx;
      lhs = crs * crs;
      len2 = dx * dx + dy * dy;
      rhs = rad * rad * len2;
      return rhs >= lhs;
   endfunction

   function automatic logic signed [COORD_W-1:0] to_coord(longint v);
      if (v > longint'(CMAX)) return CMAX;
      if (v < longint'(CMIN)) return CMIN;
      return v[COORD_W-1:0];
   endfunction

   function automatic crossing_query_type row_query(directed_row_type row);
      crossing_query_type q;
      q = '0;
      q.start_x  = row.sx;
      q.start_y  = row.sy;
      q.end_x    = row.ex;
      q.end_y    = row.ey;
      q.center_x = row.cx;
      q.center_y = row.cy;
      q.radius   = row.r[RAD_W-1:0];
      return q;
   endfunction

   // mostly centers placed near the segment with comparable radii; some noise
   function automatic crossing_query_type random_query();
      crossing_query_type q;
      int     mode, sh, osh, rsh, t;
      longint sx, sy, ex, ey, mx, my;
      q = '0;
      mode = $urandom_range(0, 9);
      sh = $urandom_range(0, 30);
      osh = sh + $urandom_range(0, 8);
      if (osh > 31) osh = 31;
      rsh = osh - 2 + $urandom_range(0, 4);
      if (rsh < 0) rsh = 0;
      if (rsh > 31) rsh = 31;
      sx = int'($urandom) >>> sh;
      sy = int'($urandom) >>> sh;
      ex = int'($urandom) >>> sh;
      ey = int'($urandom) >>> sh;
      t = $urandom_range(0, 20);
      mx = sx + (ex - sx) * t / 16;
      my = sy + (ey - sy) * t / 16;
      q.start_x  = sx[COORD_W-1:0];
      q.start_y  = sy[COORD_W-1:0];
      q.end_x    = ex[COORD_W-1:0];
      q.end_y    = ey[COORD_W-1:0];
      q.center_x = to_coord(mx + (int'($urandom) >>> osh));
      q.center_y = to_coord(my + (int'($urandom) >>> osh));
      q.radius   = RAD_W'(($urandom >> 1) >> rsh);
      case (mode)
         0: begin
            q.start_x  = $urandom;
            q.start_y  = $urandom;
            q.end_x    = $urandom;
            q.end_y    = $urandom;
            q.center_x = $urandom;
            q.center_y = $urandom;
            q.radius   = RAD_W'($urandom);
         end
         1: begin
            q.end_x = q.start_x;
            q.end_y = q.start_y;
         end
         2: begin
            q.center_x = to_coord(mx);
            q.center_y = to_coord(my);
            q.radius   = '0;
         end
         default: begin
         end
      endcase
      return q;
   endfunction

   task automatic send_query(crossing_query_type q, verdict_src_type verdict);
      int gap;
      if (sent_beats % 24 == 0) req_calm = ($urandom_range(0, 2) == 0);
      gap = req_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = q;
      do @(posedge clock); while (!req_tready);
      case (verdict)
         KNOWN_CLEAR:   expected_crossings.push_back(1'b0);
         KNOWN_BLOCKED: expected_crossings.push_back(1'b1);
         default:       expected_crossings.push_back(circle_blocks_path(q));
      endcase
      sent_beats++;
      @(negedge clock);
   endtask

   initial begin
      int i;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (i = 0; i < N_ROWS; i++) begin
         send_query(row_query(directed_rows[i]), directed_rows[i].verdict);
      end
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         send_query(random_query(), BY_MODEL);
      end
      req_tvalid = 1'b0;
      while (expected_crossings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("segment_circle_crossing_test: match");
      end else begin
         $display("segment_circle_crossing_test: mismatch");
      end
      $finish;
   end

   initial begin
      int gap;
      bit want;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (taken_beats % 24 == 0) rsp_calm = ($urandom_range(0, 2) == 0);
         gap = rsp_calm ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken_beats++;
         if (expected_crossings.size() == 0) begin
            $error("crosses: expected none, actual %0b", rsp_tdata[0]);
            failures++;
         end else begin
            want = expected_crossings.pop_front();
            if (rsp_tdata[0] !== want) begin
               $error("crosses: expected %0b, actual %0b", want, rsp_tdata[0]);
               failures++;
            end
         end
         @(negedge clock);
      end
   end

endmodule
